// ----- design/sscp_pkg.sv -----
// Shared types and constants for the sensor sample cluster publisher.
// No dependencies.
package sscp_pkg;

  localparam int unsigned RowCount = 4;
  localparam int unsigned PowCount = 19;

  typedef enum logic [1:0] {
    ST_WRITTEN  = 2'd0,
    ST_NO_ROW   = 2'd1,
    ST_RANGE    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_OCC  = 2'd0,
    REG_TEMP = 2'd1,
    REG_HUM  = 2'd2,
    REG_BATT = 2'd3
  } reg_e;

  localparam logic [7:0] CodeReset [RowCount] = '{8'd2, 8'd3, 8'd4, 8'd5};
  localparam logic [6:0] RowMul [RowCount] = '{7'd1, 7'd100, 7'd100, 7'd2};
  localparam logic [14:0] RowOffMag [RowCount] = '{15'd0, 15'd27315, 15'd0, 15'd0};

  function automatic logic [63:0] tens(input logic [4:0] e);
    logic [63:0] v;
    v = 64'd1;
    unique case (e)
      5'd0:  v = 64'd1;
      5'd1:  v = 64'd10;
      5'd2:  v = 64'd100;
      5'd3:  v = 64'd1000;
      5'd4:  v = 64'd10000;
      5'd5:  v = 64'd100000;
      5'd6:  v = 64'd1000000;
      5'd7:  v = 64'd10000000;
      5'd8:  v = 64'd100000000;
      5'd9:  v = 64'd1000000000;
      5'd10: v = 64'd10000000000;
      5'd11: v = 64'd100000000000;
      5'd12: v = 64'd1000000000000;
      5'd13: v = 64'd10000000000000;
      5'd14: v = 64'd100000000000000;
      5'd15: v = 64'd1000000000000000;
      5'd16: v = 64'd10000000000000000;
      5'd17: v = 64'd100000000000000000;
      5'd18: v = 64'd1000000000000000000;
      default: v = 64'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- design/sscp_mul.sv -----
// Sequential 64x64 magnitude multiplier, 16 bits of the multiplier per cycle,
// with overflow against a limit. Depends on nothing.
module sscp_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] limit_i,
  output logic        done_o,
  output logic [63:0] prod_o,
  output logic        ovf_o
);
  logic [127:0] acc_q, acc_d;
  logic [63:0]  b_q;
  logic [63:0]  a_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [79:0]  part;

  assign part = a_q * b_q[cnt_q[1:0]*16 +: 16];
  assign acc_d = acc_q + ({48'd0, part} << (cnt_q[1:0] * 16));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[63:0];
  assign ovf_o  = (acc_q[127:64] != 64'd0) || (acc_q[63:0] > limit_i);
endmodule

// ----- design/sscp_div.sv -----
// Restoring 64-bit divider, one quotient bit per cycle, rounding half away
// from zero. Depends on nothing.
module sscp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [63:0] q_q, d_q, r_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rs, diff;
  logic [64:0] twice;

  assign rs   = {r_q, q_q[63]};
  assign diff = rs - {1'b0, d_q};
  assign twice = {r_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 7'd64) begin
        if (r_q != 64'd0 && twice >= {1'b0, d_q}) q_q <= q_q + 64'd1;
      end else if (!diff[64]) begin
        r_q <= diff[63:0];
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= rs[63:0];
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

// ----- design/sensor_sample_cluster_publish_core.sv -----
// Sensor sample to cluster attribute publisher, top level.
// Depends on sscp_pkg, sscp_mul and sscp_div.
// One item is processed at a time. A successful conversion goes through four parts
// in order. A multiplication by the power of ten comes first and is skipped for a
// negative exponent. A multiplication by the row multiplier and a divider follow.
// Last comes a search of the endpoint memory, one entry in use after another.
// An item with no matching row or an exponent out of range goes from idle straight
// to the output state, and a multiplication overflow ends the item once that
// multiplication is done. The input stays stalled until the result has been taken.
// The endpoint table lives in a synchronous memory that is read one entry at a time.
module sensor_sample_cluster_publish_core import sscp_pkg::*; #(
  parameter int unsigned MAX_ENDPOINTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] source_id_i,
  input  logic [7:0]  field_number_i,
  input  logic [7:0]  type_code_i,
  input  logic signed [63:0] raw_value_i,
  input  logic signed [7:0]  exponent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] endpoint_number_o,
  output logic [1:0]  row_index_o,
  output logic signed [63:0] cluster_value_o
);
  localparam int unsigned IdxW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENDPOINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL1W, S_MUL2, S_MUL2W, S_DIV, S_DIVW, S_SRCH, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0]  code_q [RowCount];
  logic [31:0] src_q;
  logic [7:0]  fld_q;
  logic        neg_q;
  logic [63:0] mag_q, den_q, limit_q, val_q;
  logic [1:0]  row_q;
  logic [CntW-1:0] used_q, slot_q;
  logic        rd_pend_q;
  logic [39:0] mem [MAX_ENDPOINTS];
  logic [39:0] rd_q;
  logic        out_valid_q;
  logic [1:0]  st_q;
  logic [15:0] ep_q;

  logic mul_start, mul_done, mul_ovf, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_p, div_q;

  // Config port.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RowCount; i++) code_q[i] <= CodeReset[i];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      unique case (reg_e'(paddr[3:2]))
        REG_OCC:  code_q[0] <= pwdata[7:0];
        REG_TEMP: code_q[1] <= pwdata[7:0];
        REG_HUM:  code_q[2] <= pwdata[7:0];
        REG_BATT: code_q[3] <= pwdata[7:0];
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) prdata = {24'd0, code_q[paddr[3:2]]};
  end

  // Row match and exponent decode on the incoming item.
  logic       hit;
  logic [1:0] row_m;
  always_comb begin
    hit = 1'b0;
    row_m = 2'd0;
    for (int i = RowCount - 1; i >= 0; i--) begin
      if (code_q[i] == type_code_i) begin
        hit = 1'b1;
        row_m = 2'(i);
      end
    end
  end
  logic       eneg;
  logic [7:0] emag;
  assign eneg = exponent_i[7];
  assign emag = eneg ? (8'd0 - exponent_i) : exponent_i;
  logic       in_neg;
  logic [63:0] in_mag, in_lim;
  assign in_neg = raw_value_i[63];
  assign in_mag = in_neg ? (64'd0 - raw_value_i) : raw_value_i;
  assign in_lim = in_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  logic acc_in;
  assign acc_in = in_valid_i && !in_stall_o;

  sscp_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .limit_i(limit_q), .done_o(mul_done), .prod_o(mul_p), .ovf_o(mul_ovf)
  );
  sscp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(mag_q), .den_i(den_q),
    .done_o(div_done), .quot_o(div_q)
  );

  assign mul_start = (state_q == S_MUL1) || (state_q == S_MUL2);
  assign mul_a = mag_q;
  assign mul_b = (state_q == S_MUL1) ? den_q : {57'd0, RowMul[row_q]};
  assign div_start = (state_q == S_DIV);

  // Rounded value with sign and offset.
  logic [63:0] qv, fin;
  logic        fneg, offovf;
  assign qv = div_q;
  assign fneg = neg_q && (qv != 64'd0);
  assign offovf = fneg && (qv > 64'h8000_0000_0000_0000 - {49'd0, RowOffMag[row_q]});
  assign fin = fneg ? (64'd0 - qv - {49'd0, RowOffMag[row_q]})
                    : (qv - {49'd0, RowOffMag[row_q]});

  logic match;
  assign match = (rd_q[39:8] == src_q) && (rd_q[7:0] == fld_q);

  always_ff @(posedge clk_i) begin
    rd_q <= mem[slot_q[IdxW-1:0]];
    if (state_q == S_SRCH && rd_pend_q && slot_q == used_q
        && used_q < CntW'(MAX_ENDPOINTS)) begin
      mem[slot_q[IdxW-1:0]] <= {src_q, fld_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      slot_q      <= '0;
      rd_pend_q   <= 1'b0;
      st_q        <= ST_WRITTEN;
      ep_q        <= '0;
      row_q       <= '0;
      val_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc_in) begin
          src_q   <= source_id_i;
          fld_q   <= field_number_i;
          neg_q   <= in_neg;
          mag_q   <= in_mag;
          limit_q <= in_lim;
          row_q   <= row_m;
          den_q   <= tens(emag[4:0]);
          ep_q    <= '0;
          val_q   <= '0;
          if (!hit) begin
            st_q <= ST_NO_ROW;
            state_q <= S_OUT;
          end else if (emag >= 8'(PowCount)) begin
            st_q <= ST_RANGE;
            state_q <= S_OUT;
          end else begin
            state_q <= eneg ? S_MUL2 : S_MUL1;
          end
        end
        S_MUL1: state_q <= S_MUL1W;
        S_MUL1W: if (mul_done) begin
          if (mul_ovf) begin
            st_q <= ST_RANGE;
            state_q <= S_OUT;
          end else begin
            mag_q <= mul_p;
            den_q <= 64'd1;
            state_q <= S_MUL2;
          end
        end
        S_MUL2: state_q <= S_MUL2W;
        S_MUL2W: if (mul_done) begin
          if (mul_ovf) begin
            st_q <= ST_RANGE;
            state_q <= S_OUT;
          end else begin
            mag_q <= mul_p;
            state_q <= S_DIV;
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: if (div_done) begin
          if (offovf) begin
            st_q <= ST_RANGE;
            state_q <= S_OUT;
          end else begin
            val_q <= fin;
            slot_q <= '0;
            rd_pend_q <= 1'b0;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          // rd_q holds the entry at slot_q once rd_pend_q is set.
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else if (slot_q < used_q && match) begin
            st_q <= ST_WRITTEN;
            ep_q <= 16'(slot_q) + 16'd1;
            state_q <= S_OUT;
          end else if (slot_q < used_q) begin
            slot_q <= slot_q + CntW'(1);
            rd_pend_q <= 1'b0;
          end else if (used_q >= CntW'(MAX_ENDPOINTS)) begin
            st_q <= ST_FULL;
            val_q <= '0;
            state_q <= S_OUT;
          end else begin
            st_q <= ST_WRITTEN;
            ep_q <= 16'(slot_q) + 16'd1;
            used_q <= used_q + CntW'(1);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (st_q != ST_WRITTEN) val_q <= '0;
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = st_q;
  assign endpoint_number_o = ep_q;
  assign row_index_o       = row_q;
  assign cluster_value_o   = val_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MAX_ENDPOINTS)) else $error("endpoint count exceeds table size");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !acc_in) else $error("item accepted while busy");
  a_ep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && st_q != ST_WRITTEN) |-> (ep_q == 16'd0 && val_q == 64'd0))
    else $error("failed item carries endpoint or value");
  a_used_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + CntW'(1)))
    else $error("endpoint count jumped");
endmodule

// ----- bench/sensor_sample_cluster_publish_core_tb.sv -----
// Testbench for sensor_sample_cluster_publish_core: drives sensor samples and APB
// register writes, predicts every result with its own conversion and endpoint table.
// Depends on sscp_pkg and the core RTL only.
`timescale 1ns / 100ps

module sensor_sample_cluster_publish_core_tb;
  import sscp_pkg::*;

  localparam int unsigned TableDepth = 32;
  localparam longint unsigned SignBit = 64'h8000000000000000;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic [31:0] source_id;
    logic [7:0]  field_number;
    logic [7:0]  type_code;
    logic [63:0] raw_value;
    logic [7:0]  exponent;
  } sample_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] endpoint_number;
    logic [1:0]  row_index;
    logic [63:0] cluster_value;
  } publish_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] source_id_i = '0;
  logic [7:0] field_number_i = '0, type_code_i = '0;
  logic signed [63:0] raw_value_i = '0;
  logic signed [7:0] exponent_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o, row_index_o;
  logic [15:0] endpoint_number_o;
  logic signed [63:0] cluster_value_o;

  sensor_sample_cluster_publish_core dut (.*);

  always #1 clk_i = ~clk_i;

  logic [7:0] row_code [RowCount];
  logic [31:0] known_source [TableDepth];
  logic [7:0] known_field [TableDepth];
  int unsigned known_count;
  publish_t pending_publish [$];
  int unsigned mismatches, results_seen, cycles, samples_sent;
  bit hold_off;
  bit sender_bursty;

  function automatic bit scale_mag(bit neg, ref longint unsigned mag, input longint unsigned k);
    longint unsigned limit;
    limit = neg ? SignBit : SignBit - 1;
    if (mag > limit / k) return 1'b0;
    mag = mag * k;
    return 1'b1;
  endfunction

  function automatic publish_t predict_publish(sample_t s);
    publish_t p;
    int row;
    bit neg;
    longint unsigned mag, den, q, r, mul, off, val;
    int unsigned e, slot;
    p = '0;
    p.status = ST_WRITTEN;
    row = -1;
    for (int i = RowCount - 1; i >= 0; i--)
      if (row_code[i] == s.type_code) row = i;
    if (row < 0) begin
      p.status = ST_NO_ROW;
      return p;
    end
    p.row_index = row[1:0];
    mul = (row == 0) ? 1 : (row == 3) ? 2 : 100;
    off = (row == 1) ? 27315 : 0;
    neg = s.raw_value[63];
    mag = neg ? -s.raw_value : s.raw_value;
    den = 1;
    e = s.exponent;
    if (e >= 128) begin
      e = 256 - e;
      if (e >= PowCount) begin p.status = ST_RANGE; return p; end
      den = 1;
      repeat (e) den = den * 10;
    end else begin
      if (e >= PowCount) begin p.status = ST_RANGE; return p; end
      for (int k = 0; k < e; k++)
        if (!scale_mag(neg, mag, 10)) begin p.status = ST_RANGE; return p; end
    end
    if (!scale_mag(neg, mag, mul)) begin p.status = ST_RANGE; return p; end
    q = mag / den;
    r = mag % den;
    if (r != 0 && r >= den - r) q++;
    if (q == 0) neg = 1'b0;
    if (neg) begin
      if (q > SignBit - off) begin p.status = ST_RANGE; return p; end
      val = -q - off;
    end else val = q - off;
    slot = known_count;
    for (int unsigned i = 0; i < known_count; i++)
      if (slot == known_count && known_source[i] == s.source_id &&
          known_field[i] == s.field_number) slot = i;
    if (slot == known_count) begin
      if (known_count >= TableDepth) begin p.status = ST_FULL; return p; end
      known_source[slot] = s.source_id;
      known_field[slot] = s.field_number;
      known_count++;
    end
    p.endpoint_number = 16'(slot + 1);
    p.cluster_value = val;
    return p;
  endfunction

  // Stepwise scaling by ten matches one multiplication by 10^e for overflow purposes.

  task automatic write_code(reg_e idx, logic [7:0] code);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    row_code[idx] = code;
  endtask

  task automatic set_codes(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
    write_code(REG_OCC, a);
    write_code(REG_TEMP, b);
    write_code(REG_HUM, c);
    write_code(REG_BATT, d);
  endtask

  task automatic send_sample(sample_t s);
    @(posedge clk_i);
    if (sender_bursty && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    in_valid_i <= 1'b1;
    source_id_i <= s.source_id;
    field_number_i <= s.field_number;
    type_code_i <= s.type_code;
    raw_value_i <= s.raw_value;
    exponent_i <= s.exponent;
    do @(posedge clk_i); while (in_stall_o);
    pending_publish.push_back(predict_publish(s));
    samples_sent++;
    in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_publish.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 3) == 0) && cycles[9];
  end

  always @(posedge clk_i) begin
    publish_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_e'(status_o), endpoint_number_o, row_index_o, cluster_value_o};
      results_seen++;
      if (pending_publish.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_publish.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("sensor_sample_cluster_publish_core_tb failed");
      $finish;
    end
  end

  function automatic sample_t random_sample(int unsigned src_span);
    sample_t s;
    s.source_id = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, src_span);
    s.field_number = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3);
    s.type_code = $urandom_range(0, 5) == 0 ? $urandom() : row_code[$urandom_range(0, 3)];
    case ($urandom_range(0, 3))
      0: s.raw_value = {$urandom(), $urandom()};
      1: s.raw_value = $signed(64'(int'($urandom_range(0, 2000)) - 1000));
      2: s.raw_value = $signed({{32{$urandom_range(0, 1) == 1}}, $urandom()});
      default: s.raw_value = $urandom_range(0, 1) ? 64'h7fffffffffffffff >> $urandom_range(0, 63)
                                                  : 64'h8000000000000000 >>> $urandom_range(0, 63);
    endcase
    s.exponent = $urandom_range(0, 7) == 0 ? 8'($urandom()) : 8'($signed($urandom_range(0, 44)) - 22);
    return s;
  endfunction

  task automatic test_directed;
    sample_t s;
    longint unsigned raws [6] = '{64'd0, 64'd5, -64'd5, 64'h7fffffffffffffff,
                                  64'h8000000000000000, 64'd15};
    logic [7:0] exps [6] = '{8'd0, 8'd18, 8'd19, -8'd18, -8'd19, -8'd1};
    for (int i = 0; i < 6; i++) begin
      s = '{32'hffffffff - i, 8'hff, row_code[i % 4], raws[i], exps[i]};
      send_sample(s);
      s = '{32'd0, 8'd0, row_code[(i + 1) % 4], raws[5 - i], exps[5 - i]};
      send_sample(s);
    end
    send_sample('{32'd1, 8'd1, 8'd200, 64'd1, 8'd0});
    send_sample('{32'd1, 8'd1, 8'h03, -64'd25, -8'd1});
    send_sample('{32'd1, 8'd1, 8'h03, 64'h8000000000000000, -8'd2});
    send_sample('{32'd1, 8'd1, 8'h03, 64'sd92233720368547758, 8'd0});
    send_sample('{32'd1, 8'd1, 8'h05, 64'h4000000000000000, 8'd0});
    send_sample('{32'd1, 8'd1, 8'h05, 64'hc000000000000000, 8'd0});
    send_sample('{32'd1, 8'd1, 8'h80, 64'd1, 8'h80});
    drain();
  endtask

  task automatic test_duplicate_codes;
    set_codes(8'h00, 8'h00, 8'hff, 8'hff);
    send_sample('{32'd7, 8'd0, 8'h00, 64'd3, 8'd1});
    send_sample('{32'd7, 8'd0, 8'hff, 64'd3, 8'd1});
    drain();
  endtask

  task automatic test_random(int unsigned count, int unsigned src_span);
    for (int unsigned i = 0; i < count; i++) begin
      send_sample(random_sample(src_span));
      if (i == count / 2) sender_bursty = ~sender_bursty;
    end
    drain();
  endtask

  task automatic test_table_full;
    for (int unsigned i = 0; i < 60; i++)
      send_sample('{32'h1000 + i, 8'(i), row_code[0], 64'(i), 8'd0});
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_sample(random_sample(40));
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < RowCount; i++) row_code[i] = CodeReset[i];
    known_count = 0;
    sender_bursty = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_duplicate_codes();
    set_codes(8'h00, 8'hff, 8'h5a, 8'ha5);
    test_random(400, 40);
    set_codes(8'd2, 8'd3, 8'd4, 8'd5);
    test_random(600, 40);
    test_backpressure();
    set_codes(8'h11, 8'h22, 8'h33, 8'h44);
    test_table_full();
    test_random(700, 20);
    $display("%0d samples sent, %0d results checked, %0d endpoints allocated",
             samples_sent, results_seen, known_count);
    $display("covered extremes, all rows, duplicate codes, range errors and a full table");
    if (mismatches == 0 && pending_publish.size() == 0)
      $display("sensor_sample_cluster_publish_core_tb passed");
    else
      $display("sensor_sample_cluster_publish_core_tb failed");
    $finish;
  end

endmodule
